/* rtl/ctmb_pkg.sv */
// ============================================================================
// ctmb_pkg: shared types and constants of the clipped tile map blitter
// Holds the map geometry, the channel payload structs and the record that
// travels from the front end to the back end through the queue.
// ============================================================================
`default_nettype none

package ctmb_pkg;

	// Map geometry.
	localparam int MAP_COLUMNS  = 32;
	localparam int VISIBLE_ROWS = 24;
	localparam int LAYER_COUNT  = 3;

	// Width of a visible row number and of a visible column number.
	localparam int ROW_W  = (VISIBLE_ROWS > 1) ? $clog2(VISIBLE_ROWS) : 1;
	localparam int COL_W  = $clog2(MAP_COLUMNS);
	localparam int CELL_W = 10;

	// Queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic              first_word;
		logic              plane_engine;
		logic [1:0]        layer;
		logic signed [7:0] origin_x;
		logic signed [7:0] origin_y;
		logic [7:0]        rect_width;
		logic [7:0]        rect_height;
		logic [3:0]        palette_number;
		logic [15:0]       tile_word;
	} item_t;

	typedef struct packed {
		logic              write_valid;
		logic              target_engine;
		logic [1:0]        target_layer;
		logic [CELL_W-1:0] cell_index;
		logic [15:0]       cell_data;
	} result_t;

	// One classified word: visible position and final data.
	typedef struct packed {
		logic             write;
		logic             engine;
		logic [1:0]       layer;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [15:0]      data;
	} rec_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

`default_nettype wire

/* rtl/clipped_tilemap_blit_core.sv */
// ============================================================================
// clipped_tilemap_blit_core: clipped rectangle blit into a tile map
// Streams the source words of tile rectangles and gives one result per word,
// a map write when the cell is visible and a no-write result otherwise.
// ============================================================================
//
//  Channel  Direction  Handshake              Payload
//  item     in         item_valid/item_stall  item_t (one source word)
//  result   out        result_valid/result_stall  result_t (one result, a map write or a no-write)
//
// One word is taken per cycle while the queue has room; a result leaves once
// its word has passed the queue entry and then the result register.
// Sustained rate is one transaction per cycle on each channel while result_stall stays low.
// Reset clears the rectangle counters, the queue pointers and the result
// valid flag; no rectangle is active after reset.
// A stall on the result side first fills the two-entry queue, and item_stall
// rises only when the queue is full.
//
// The front end keeps the rectangle state (origin, width, palette, target
// map, column offset, current row, rows left). A word with first_word set
// replaces that state and is also the first word of its rectangle. The back
// end forms the cell index as row times the map width plus column and clears
// every field of a result that does not write.

`default_nettype none

module clipped_tilemap_blit_core import ctmb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	rec_t   front_rec;
	rec_t   queue_rec;
	qstat_t q_stat;
	logic   take;
	logic   pop;

	// A transaction is taken whenever the queue can hold its record.
	assign item_stall = q_stat.full;
	assign take       = item_valid && !q_stat.full;

	ctmb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.rec    (front_rec)
	);

	ctmb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_rec (front_rec),
		.pop      (pop),
		.pop_rec  (queue_rec),
		.stat     (q_stat)
	);

	ctmb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec          (queue_rec),
		.rec_valid    (!q_stat.empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A result that does not write carries all-zero fields.
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_valid |->
			result.target_engine == 1'b0 && result.target_layer == 2'd0
			&& result.cell_index == '0 && result.cell_data == 16'h0000)
		else $error("no-write result has nonzero fields");

	// Writes never target a layer map that does not exist.
	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_valid |->
			{1'b0, result.target_layer} < 3'(LAYER_COUNT))
		else $error("write to a nonexistent layer");

	// The queue occupancy stays within its depth and moves by at most one.
	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH)
		&& (q_stat.count == $past(q_stat.count)
			|| q_stat.count == $past(q_stat.count) + 1'b1
			|| q_stat.count == $past(q_stat.count) - 1'b1))
		else $error("queue occupancy out of range");

endmodule

`default_nettype wire

/* rtl/ctmb_front.sv */
// ============================================================================
// ctmb_front: rectangle tracking and clipping
// Latches the rectangle geometry on a first word, walks the column and row
// counters and classifies every word as a map write or a skipped word.
// ============================================================================
`default_nettype none

module ctmb_front import ctmb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire item_t item,
	output rec_t       rec
);

	logic [7:0] column_offset_q;
	logic [9:0] current_row_q;
	logic [7:0] rows_left_q;
	logic [7:0] left_q;
	logic [7:0] width_q;
	logic [3:0] palette_q;
	logic       engine_q;
	logic [1:0] layer_q;

	// State as seen by this word: a first word overrides the latched values.
	logic [7:0] off_e;
	logic [9:0] row_e;
	logic [7:0] rows_e;
	logic [7:0] left_e;
	logic [7:0] width_e;
	logic [3:0] palette_e;
	logic       engine_e;
	logic [1:0] layer_e;
	logic [9:0] col_e;
	logic [7:0] off_inc;
	logic       row_done;
	logic       hit;

	always_comb begin
		if (item.first_word) begin
			off_e     = 8'd0;
			row_e     = {{2{item.origin_y[7]}}, item.origin_y};
			left_e    = item.origin_x;
			width_e   = item.rect_width;
			palette_e = item.palette_number;
			engine_e  = item.plane_engine;
			layer_e   = item.layer;
			rows_e    = (item.rect_width == 8'd0 || item.rect_height == 8'd0) ?
				8'd0 : item.rect_height;
		end else begin
			off_e     = column_offset_q;
			row_e     = current_row_q;
			left_e    = left_q;
			width_e   = width_q;
			palette_e = palette_q;
			engine_e  = engine_q;
			layer_e   = layer_q;
			rows_e    = rows_left_q;
		end
		col_e    = {{2{left_e[7]}}, left_e} + {2'b00, off_e};
		off_inc  = off_e + 8'd1;
		row_done = (off_inc >= width_e);
		hit = (rows_e != 8'd0)
			&& !row_e[9] && (row_e < 10'(VISIBLE_ROWS))
			&& !col_e[9] && (col_e < 10'(MAP_COLUMNS))
			&& ({1'b0, layer_e} < 3'(LAYER_COUNT));
		rec.write  = hit;
		rec.engine = engine_e;
		rec.layer  = layer_e;
		rec.row    = ROW_W'(row_e);
		rec.col    = COL_W'(col_e);
		rec.data   = item.tile_word | {palette_e, 12'h000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= '0;
			current_row_q   <= '0;
			rows_left_q     <= '0;
			left_q          <= '0;
			width_q         <= '0;
			palette_q       <= '0;
			engine_q        <= 1'b0;
			layer_q         <= '0;
		end else if (take) begin
			left_q    <= left_e;
			width_q   <= width_e;
			palette_q <= palette_e;
			engine_q  <= engine_e;
			layer_q   <= layer_e;
			if (rows_e == 8'd0) begin
				column_offset_q <= off_e;
				current_row_q   <= row_e;
				rows_left_q     <= rows_e;
			end else if (row_done) begin
				column_offset_q <= 8'd0;
				current_row_q   <= row_e + 10'd1;
				rows_left_q     <= rows_e - 8'd1;
			end else begin
				column_offset_q <= off_inc;
				current_row_q   <= row_e;
				rows_left_q     <= rows_e;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ctmb_queue.sv */
// ============================================================================
// ctmb_queue: short record queue
// Decouples the front end from the back end so each side can stall alone.
// ============================================================================
`default_nettype none

module ctmb_queue import ctmb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t push_rec,
	input  wire logic pop,
	output rec_t      pop_rec,
	output qstat_t    stat
);

	rec_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_rec    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ctmb_back.sv */
// ============================================================================
// ctmb_back: map address generation and result register
// Turns a classified record into the cell address and holds the result
// until the downstream side takes it.
// ============================================================================
`default_nettype none

module ctmb_back import ctmb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rec_t rec,
	input  wire logic rec_valid,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	logic              valid_q;
	result_t           result_q;
	logic [CELL_W-1:0] row_ext;
	logic [CELL_W-1:0] col_ext;
	result_t           next_res;

	always_comb begin
		row_ext  = CELL_W'(rec.row);
		col_ext  = CELL_W'(rec.col);
		next_res = '0;
		if (rec.write) begin
			next_res.write_valid   = 1'b1;
			next_res.target_engine = rec.engine;
			next_res.target_layer  = rec.layer;
			next_res.cell_index    = CELL_W'(row_ext * CELL_W'(MAP_COLUMNS)) + col_ext;
			next_res.cell_data     = rec.data;
		end
	end

	assign pop          = rec_valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
